// ===== rtl/gscrc_pkg.sv =====
// shared constants, types and the crc-8 byte update for the sensor frame decoder
package gscrc_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned POS_W     = 4;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned CO2_W     = 16;
    localparam int unsigned TEMP_W    = 15;
    localparam int unsigned HUM_W     = 14;
    localparam int unsigned M_TDATA_W = 48;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

    localparam logic [POS_W-1:0] FRAME_LEN = 4'd9;
    localparam logic [POS_W-1:0] LAST_POS  = 4'd8;

    // byte positions that close each data word
    localparam logic [POS_W-1:0] POS_CO2_LOW  = 4'd1;
    localparam logic [POS_W-1:0] POS_TEMP_LOW = 4'd4;
    localparam logic [POS_W-1:0] POS_HUM_LOW  = 4'd7;

    // fixed-point conversion: value = (scale * raw) >> 16, minus offset for temperature
    localparam logic [14:0]       TEMP_SCALE  = 15'd17500;
    localparam logic [13:0]       HUM_SCALE   = 14'd10000;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd4500;

    typedef enum logic [1:0] {
        PH_HIGH  = 2'd0,
        PH_LOW   = 2'd1,
        PH_CHECK = 2'd2
    } phase_t;

    function automatic phase_t byte_phase(input logic [POS_W-1:0] pos);
        phase_t ph;
        unique case (pos)
            4'd0, 4'd3, 4'd6: ph = PH_HIGH;
            4'd1, 4'd4, 4'd7: ph = PH_LOW;
            default:          ph = PH_CHECK;
        endcase
        return ph;
    endfunction

    // msb-first crc-8 over one byte
    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/gas_sensor_frame_crc_decode_top.sv =====
// sensor measurement frame decoder: per-word crc-8 check and fixed-point conversion
//
//  channel | dir | payload
//  s_      | in  | tdata[7:0] data_byte, tuser frame_start
//  m_      | out | tdata co2_ppm[15:0], temperature_centi[30:16], humidity_centi[44:31];
//          |     | tuser status
//
// one byte per cycle while no result is held; a byte passes through the input register and
// its effect then lands in the state/result registers.
// the ninth byte of a frame raises m_tvalid once it is processed out of the input register.
// a held result stalls the input register and the frame state; one more byte is taken meanwhile.
// reset clears the byte count, word store and last good values and sets the crc to its initial value.
module gas_sensor_frame_crc_decode_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gscrc_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                            s_tuser,   // [0] frame_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gscrc_pkg::M_TDATA_W-1:0] m_tdata,   // [15:0] co2, [30:16] temp, [44:31] hum
    output logic                            m_tuser    // [0] status
);

    // input register
    logic                          in_valid_reg;
    logic [gscrc_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                          in_start_reg;

    // frame state
    logic [gscrc_pkg::POS_W-1:0]   byte_pos_reg, byte_pos_next;
    logic [gscrc_pkg::BYTE_W-1:0]  crc_reg, crc_next;
    logic [gscrc_pkg::BYTE_W-1:0]  high_reg;
    logic [gscrc_pkg::WORD_W-1:0]  co2_word_reg, temp_word_reg, hum_word_reg;
    logic                          mismatch_reg, mismatch_next;

    // result register: last good values and status
    logic [gscrc_pkg::CO2_W-1:0]   good_co2_reg;
    logic [gscrc_pkg::TEMP_W-1:0]  good_temp_reg, good_temp_next;
    logic [gscrc_pkg::HUM_W-1:0]   good_hum_reg, good_hum_next;
    logic                          status_reg;
    logic                          m_valid_reg;

    logic                          proceed;
    logic                          process;
    logic [gscrc_pkg::POS_W-1:0]   pos_eff;
    gscrc_pkg::phase_t             phase;
    logic [gscrc_pkg::BYTE_W-1:0]  crc_step;
    logic                          frame_done;
    logic [30:0]                   temp_prod;
    logic [29:0]                   hum_prod;

    assign proceed  = !m_valid_reg || m_tready;
    assign process  = in_valid_reg && proceed;
    assign s_tready = !in_valid_reg || proceed;

    always_comb begin
        if (in_start_reg || (byte_pos_reg >= gscrc_pkg::FRAME_LEN)) begin
            pos_eff = '0;
        end else begin
            pos_eff = byte_pos_reg;
        end
        phase      = gscrc_pkg::byte_phase(pos_eff);
        frame_done = (pos_eff == gscrc_pkg::LAST_POS);

        crc_step = gscrc_pkg::crc8_update(
            (phase == gscrc_pkg::PH_HIGH) ? gscrc_pkg::CRC_INIT : crc_reg, in_byte_reg);

        mismatch_next = (pos_eff == '0) ? 1'b0 : mismatch_reg;
        unique case (phase)
            gscrc_pkg::PH_HIGH,
            gscrc_pkg::PH_LOW:   crc_next = crc_step;
            gscrc_pkg::PH_CHECK: begin
                crc_next = gscrc_pkg::CRC_INIT;
                if (crc_reg != in_byte_reg) begin
                    mismatch_next = 1'b1;
                end
            end
            default:             crc_next = gscrc_pkg::CRC_INIT;
        endcase

        byte_pos_next = frame_done ? '0 : pos_eff + 4'd1;

        temp_prod      = 31'(gscrc_pkg::TEMP_SCALE) * 31'(temp_word_reg);
        hum_prod       = 30'(gscrc_pkg::HUM_SCALE) * 30'(hum_word_reg);
        good_temp_next = temp_prod[30:16] - gscrc_pkg::TEMP_OFFSET;
        good_hum_next  = hum_prod[29:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (process) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg  <= '0;
            crc_reg       <= gscrc_pkg::CRC_INIT;
            high_reg      <= '0;
            co2_word_reg  <= '0;
            temp_word_reg <= '0;
            hum_word_reg  <= '0;
            mismatch_reg  <= 1'b0;
            good_co2_reg  <= '0;
            good_temp_reg <= '0;
            good_hum_reg  <= '0;
            status_reg    <= 1'b0;
        end else if (process) begin
            byte_pos_reg <= byte_pos_next;
            crc_reg      <= crc_next;
            mismatch_reg <= mismatch_next;
            if (phase == gscrc_pkg::PH_HIGH) begin
                high_reg <= in_byte_reg;
            end
            if (pos_eff == gscrc_pkg::POS_CO2_LOW) begin
                co2_word_reg <= {high_reg, in_byte_reg};
            end
            if (pos_eff == gscrc_pkg::POS_TEMP_LOW) begin
                temp_word_reg <= {high_reg, in_byte_reg};
            end
            if (pos_eff == gscrc_pkg::POS_HUM_LOW) begin
                hum_word_reg <= {high_reg, in_byte_reg};
            end
            if (frame_done) begin
                status_reg <= mismatch_next;
                // last good values only move on a clean frame
                if (!mismatch_next) begin
                    good_co2_reg  <= co2_word_reg;
                    good_temp_reg <= good_temp_next;
                    good_hum_reg  <= good_hum_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (process && frame_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, good_hum_reg, good_temp_reg, good_co2_reg};

endmodule

// ===== rtl/gscrc_checker.sv =====
// port-level checker for the sensor frame decoder, bound to the top level
module gscrc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [gscrc_pkg::BYTE_W-1:0]    s_tdata,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [gscrc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser
);

    logic [gscrc_pkg::TEMP_W-1:0] temp_field;
    logic [gscrc_pkg::HUM_W-1:0]  hum_field;

    assign temp_field = m_tdata[30:16];
    assign hum_field  = m_tdata[44:31];

    // no result comes out of reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // with no result pending the input side is never blocked
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> hum_field <= 14'd9999)
        else $error("humidity out of range");

    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(temp_field) >= -15'sd4500) && ($signed(temp_field) <= 15'sd12999))
        else $error("temperature out of range");

endmodule

bind gas_sensor_frame_crc_decode_top gscrc_checker u_gscrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== bench/gas_sensor_frame_crc_decode_checker.sv =====
// checker for the sensor frame decoder: mirrors the decode of each item and compares readings
module gas_sensor_frame_crc_decode_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [gscrc_pkg::BYTE_W-1:0]    s_tdata,    // [7:0] data_byte
    input  logic                            s_tuser,    // [0] frame_start
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [gscrc_pkg::M_TDATA_W-1:0] m_tdata,    // [15:0] co2, [30:16] temp, [44:31] hum
    input  logic                            m_tuser,    // [0] status
    input  logic                            end_check,
    output int                              mismatch_count,
    output int                              readings_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CO2_W     = gscrc_pkg::CO2_W;
    localparam int unsigned TEMP_W    = gscrc_pkg::TEMP_W;
    localparam int unsigned HUM_W     = gscrc_pkg::HUM_W;
    localparam int unsigned BYTE_W    = gscrc_pkg::BYTE_W;
    localparam int unsigned M_TDATA_W = gscrc_pkg::M_TDATA_W;
    localparam int unsigned TEMP_LSB  = CO2_W;
    localparam int unsigned HUM_LSB   = CO2_W + TEMP_W;
    localparam int unsigned PAD_LSB   = CO2_W + TEMP_W + HUM_W;

    typedef struct packed {
        logic [CO2_W-1:0]  co2;
        logic [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]  hum;
        logic              crc_fail;
    } reading_t;

    reading_t expected_readings[$];

    logic [gscrc_pkg::POS_W-1:0]  next_pos;
    logic [BYTE_W-1:0]            word_crc;
    logic [BYTE_W-1:0]            high_hold;
    logic [gscrc_pkg::WORD_W-1:0] words [3];
    logic                         crc_bad;
    logic [CO2_W-1:0]             last_co2;
    logic [TEMP_W-1:0]            last_temp;
    logic [HUM_W-1:0]             last_hum;

    initial begin
        mismatch_count = 0;
        readings_due   = 0;
    end

    // bit-serial form of the msb-first crc-8
    function automatic logic [BYTE_W-1:0] crc_step(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        logic              fb;
        c = crc;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb = c[BYTE_W-1] ^ b[i];
            c  = {c[BYTE_W-2:0], 1'b0} ^ (fb ? gscrc_pkg::CRC_POLY : '0);
        end
        return c;
    endfunction

    task automatic flag_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic clear_state();
        next_pos  = '0;
        word_crc  = gscrc_pkg::CRC_INIT;
        high_hold = '0;
        for (int i = 0; i < 3; i++) begin
            words[i] = '0;
        end
        crc_bad   = 1'b0;
        last_co2  = '0;
        last_temp = '0;
        last_hum  = '0;
        expected_readings.delete();
    endtask

    task automatic absorb_byte(input logic [BYTE_W-1:0] b, input logic start);
        logic [gscrc_pkg::POS_W-1:0] pos;
        logic [31:0]                 t_full;
        logic [31:0]                 h_full;
        int                          w;
        pos = (start || next_pos > gscrc_pkg::LAST_POS) ? '0 : next_pos;
        if (pos == '0) begin
            crc_bad = 1'b0;
        end
        w = pos / 3;
        unique case (gscrc_pkg::phase_t'(pos % 3))
            gscrc_pkg::PH_HIGH: begin
                high_hold = b;
                word_crc  = crc_step(gscrc_pkg::CRC_INIT, b);
            end
            gscrc_pkg::PH_LOW: begin
                words[w] = {high_hold, b};
                word_crc = crc_step(word_crc, b);
            end
            default: begin
                if (word_crc != b) begin
                    crc_bad = 1'b1;
                end
                word_crc = gscrc_pkg::CRC_INIT;
            end
        endcase
        if (pos != gscrc_pkg::LAST_POS) begin
            next_pos = pos + 1'b1;
        end else begin
            next_pos = '0;
            // a bad frame keeps the last good values
            if (!crc_bad) begin
                t_full    = (32'(gscrc_pkg::TEMP_SCALE) * 32'(words[1])) >> 16;
                h_full    = (32'(gscrc_pkg::HUM_SCALE) * 32'(words[2])) >> 16;
                last_co2  = words[0];
                last_temp = TEMP_W'(t_full - 32'(gscrc_pkg::TEMP_OFFSET));
                last_hum  = HUM_W'(h_full);
            end
            expected_readings.push_back(reading_t'{last_co2, last_temp, last_hum, crc_bad});
        end
    endtask

    task automatic check_reading();
        reading_t want;
        if (expected_readings.size() == 0) begin
            flag_error("unexpected reading", 32'(m_tdata[CO2_W-1:0]), '0);
            return;
        end
        want = expected_readings.pop_front();
        if (m_tdata[CO2_W-1:0] != want.co2) begin
            flag_error("co2_ppm", 32'(m_tdata[CO2_W-1:0]), 32'(want.co2));
        end
        if (m_tdata[TEMP_LSB +: TEMP_W] != want.temp) begin
            flag_error("temperature_centi", 32'(m_tdata[TEMP_LSB +: TEMP_W]), 32'(want.temp));
        end
        if (m_tdata[HUM_LSB +: HUM_W] != want.hum) begin
            flag_error("humidity_centi", 32'(m_tdata[HUM_LSB +: HUM_W]), 32'(want.hum));
        end
        if (m_tdata[M_TDATA_W-1:PAD_LSB] != '0) begin
            flag_error("tdata padding", 32'(m_tdata[M_TDATA_W-1:PAD_LSB]), '0);
        end
        if (m_tuser !== want.crc_fail) begin
            flag_error("status", 32'(m_tuser), 32'(want.crc_fail));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
        end else begin
            // a reading trails its last byte through the input and result registers, so checking first is safe
            if (m_tvalid && m_tready) begin
                check_reading();
            end
            if (s_tvalid && s_tready) begin
                absorb_byte(s_tdata, s_tuser);
            end
            if (end_check && expected_readings.size() != 0) begin
                flag_error("readings never delivered", expected_readings.size(), '0);
            end
        end
        readings_due = expected_readings.size();
    end

endmodule

// ===== bench/gas_sensor_frame_crc_decode_top_tb.sv =====
// testbench top for the sensor frame decoder: byte stimulus, receiver stalls and verdict
module gas_sensor_frame_crc_decode_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1050;
    localparam int CALM_AFTER   = 900;   // no idling from here on
    localparam int LONG_HOLD_AT = 150;
    localparam int LONG_HOLD    = 200;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    localparam int unsigned BYTE_W = gscrc_pkg::BYTE_W;
    localparam int unsigned WORD_W = gscrc_pkg::WORD_W;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [BYTE_W-1:0]               s_tdata   = '0;   // [7:0] data_byte
    logic                            s_tuser   = 1'b0; // [0] frame_start
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [gscrc_pkg::M_TDATA_W-1:0] m_tdata;          // [15:0] co2, [30:16] temp, [44:31] hum
    logic                            m_tuser;          // [0] status
    logic                            end_check = 1'b0;
    int                              mismatch_count;
    int                              readings_due;
    int                              items_sent = 0;

    always #2 aclk = ~aclk;

    gas_sensor_frame_crc_decode_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    gas_sensor_frame_crc_decode_checker frame_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .end_check      (end_check),
        .mismatch_count (mismatch_count),
        .readings_due   (readings_due)
    );

    // idling in stretches, with every fourth stretch and the tail of the run kept clean
    function automatic bit idling_on();
        return items_sent < CALM_AFTER && (items_sent / 75) % 4 != 3;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // entered and left at a falling edge; valid stays high between back-to-back items
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
        if (idling_on() && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = start;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    // three words, each followed by its crc; a set bit in spoil corrupts that word's crc
    task automatic send_frame(input logic [WORD_W-1:0] co2_w, input logic [WORD_W-1:0] temp_w,
                              input logic [WORD_W-1:0] hum_w, input logic start,
                              input logic [2:0] spoil);
        logic [WORD_W-1:0] w [3];
        logic [BYTE_W-1:0] crc;
        w[0] = co2_w;
        w[1] = temp_w;
        w[2] = hum_w;
        for (int k = 0; k < 3; k++) begin
            crc = gscrc_pkg::CRC_INIT;
            for (int i = WORD_W - 1; i >= 0; i--) begin
                crc = {crc[BYTE_W-2:0], 1'b0}
                    ^ ((crc[BYTE_W-1] ^ w[k][i]) ? gscrc_pkg::CRC_POLY : '0);
            end
            if (spoil[k]) begin
                crc ^= BYTE_W'($urandom_range(1, 255));
            end
            send_byte(w[k][15:8], start && k == 0);
            send_byte(w[k][7:0], 1'b0);
            send_byte(crc, 1'b0);
        end
    endtask

    initial begin : stimulus
        int pick;
        int n;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // partial frame dropped by a restart, a failing frame before any good one,
        // then a full-scale good frame entered by wrap-around alone
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_frame('0, '0, '0, 1'b1, 3'b001);
        send_frame('1, '1, '1, 1'b0, 3'b000);

        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                send_frame(pick_word(), pick_word(), pick_word(), $urandom_range(0, 3) != 0,
                           {$urandom_range(0, 19) < 3, $urandom_range(0, 19) < 3,
                            $urandom_range(0, 19) < 3});
            end else if (pick < 90) begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) begin
                    send_byte(BYTE_W'($urandom), i == 0);
                end
            end else begin
                send_byte(BYTE_W'($urandom), 1'($urandom));
            end
        end
        s_tvalid = 1'b0;

        while (readings_due != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        end_check = 1'b1;
        @(negedge aclk);
        end_check = 1'b0;
        @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : receiver
        int  hold;
        bit  long_done;
        hold      = 0;
        long_done = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready = 1'b0;
            end else if (!long_done && items_sent >= LONG_HOLD_AT) begin
                // long hold-off so the block fills and pushes back on the sender
                long_done = 1'b1;
                hold      = LONG_HOLD - 1;
                m_tready  = 1'b0;
            end else if (idling_on() && $urandom_range(0, 4) == 0) begin
                hold     = $urandom_range(0, 5);
                m_tready = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule
